// ----- rtl/core/xdjm_pkg.sv -----
// shared widths and defaults for the x-drive joystick mixer
package xdjm_pkg;

    localparam int AXIS_W         = 8;    // joystick axis width
    localparam int OUT_W          = 16;   // wheel speed width, percent times 256
    localparam int NUM_W          = 18;   // signed mixed numerator width
    localparam int MAG_W          = 17;   // numerator magnitude width
    localparam int DEN_W          = 9;    // |x|+|y| width
    localparam int FRAC_W         = 8;    // output fraction bits
    localparam int LANES          = 4;    // wheels
    localparam int DEF_FULL_SCALE = 100;  // default wheel limit in percent

endpackage

// ----- rtl/core/xdjm_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module xdjm_div import xdjm_pkg::*; #(
    parameter int DW = 32,
    parameter int VW = 17,
    parameter int QW = 15
) (
    input  logic          aclk,
    input  logic [QW-1:0] en,       // load enable per stage
    input  logic [DW-1:0] dvd_i,
    input  logic [VW-1:0] dvs_i,
    input  logic          neg_i,
    output logic [QW-1:0] quo_o,
    output logic          neg_o
);

    localparam int CW = VW + QW;

    logic [CW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [VW-1:0] dvs_reg [QW];
    logic          neg_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;

        logic [CW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [VW-1:0] dvs_in;
        logic          neg_in;
        logic [CW:0]   trial;
        logic [CW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (j == 0) begin : g_first
            assign rem_in = CW'(dvd_i);
            assign quo_in = '0;
            assign dvs_in = dvs_i;
            assign neg_in = neg_i;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign dvs_in = dvs_reg[j-1];
            assign neg_in = neg_reg[j-1];
        end

        always_comb begin
            trial    = {1'b0, rem_in} - ({1'b0, CW'(dvs_in)} << B);
            rem_next = rem_in;
            quo_next = quo_in;
            // no borrow means the shifted divisor fits
            if (!trial[CW]) begin
                rem_next    = trial[CW-1:0];
                quo_next[B] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[j]) begin
                rem_reg[j] <= rem_next;
                quo_reg[j] <= quo_next;
                dvs_reg[j] <= dvs_in;
                neg_reg[j] <= neg_in;
            end
        end
    end

    assign quo_o = quo_reg[QW-1];
    assign neg_o = neg_reg[QW-1];

endmodule

// ----- rtl/core/x_drive_joystick_mixer_core.sv -----
// Mixes forward, strafe and turn stick axes into four x-drive wheel speeds.
// One item is accepted per cycle while s_tready is high, and every item gives
// one result. The divider resolves one quotient bit per stage in each of four
// lanes. Stages advance independently, so a stalled output still lets items
// enter until every stage is occupied. Speeds are in percent times 256,
// truncated toward zero, and never exceed FULL_SCALE*256 in magnitude.
module x_drive_joystick_mixer_core import xdjm_pkg::*; #(
    parameter int FULL_SCALE = DEF_FULL_SCALE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // forward_axis, strafe_axis, turn_axis
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // fl, bl, fr, br wheel speed
);

    localparam int FSW  = $clog2(FULL_SCALE + 1);
    localparam int QW   = $clog2(256 * FULL_SCALE + 1);
    localparam int DW   = MAG_W + FRAC_W + FSW;
    localparam int FDW  = DEN_W + FSW;
    localparam int PRE  = 6;             // stages before the divider
    localparam int OST  = PRE + QW;      // output stage
    localparam int NST  = OST + 1;

    localparam logic [FSW-1:0] FS_C = FSW'(FULL_SCALE);

    // stage control
    logic [NST-1:0] v_reg;
    logic [NST-1:0] rdy;

    for (genvar k = 0; k < NST; k++) begin : g_rdy
        // stage k may load when the output is taken or some stage at or after it is empty
        assign rdy[k] = m_tready | ~(&v_reg[NST-1:k]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= (k == 0) ? s_tvalid : v_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = v_reg[OST];

    // stage 0: capture axes
    logic signed [AXIS_W-1:0] y0_reg, x0_reg, r0_reg;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            y0_reg <= $signed(s_tdata[7:0]);
            x0_reg <= $signed(s_tdata[15:8]);
            r0_reg <= $signed(s_tdata[23:16]);
        end
    end

    // stage 1: magnitudes, sum, larger magnitude, translation sums
    logic [AXIS_W-1:0]        ay_next, ax_next, big_next, big_reg;
    logic [DEN_W-1:0]         sum_next, den1_next, den1_reg;
    logic signed [DEN_W-1:0]  spx_next, smx_next, spx_reg, smx_reg;
    logic signed [AXIS_W-1:0] r1_reg;

    always_comb begin
        ay_next   = y0_reg[AXIS_W-1] ? (~y0_reg + 1'b1) : y0_reg;
        ax_next   = x0_reg[AXIS_W-1] ? (~x0_reg + 1'b1) : x0_reg;
        sum_next  = {1'b0, ax_next} + {1'b0, ay_next};
        // centered stick: divide by one so only turn remains
        den1_next = (sum_next == '0) ? DEN_W'(1) : sum_next;
        big_next  = (ax_next > ay_next) ? ax_next : ay_next;
        spx_next  = {y0_reg[AXIS_W-1], y0_reg} + {x0_reg[AXIS_W-1], x0_reg};
        smx_next  = {y0_reg[AXIS_W-1], y0_reg} - {x0_reg[AXIS_W-1], x0_reg};
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            big_reg  <= big_next;
            den1_reg <= den1_next;
            spx_reg  <= spx_next;
            smx_reg  <= smx_next;
            r1_reg   <= r0_reg;
        end
    end

    // stage 2: products
    logic signed [NUM_W-1:0] p_next, q_next, rd_next, p_reg, q_reg, rd_reg;
    logic [FDW-1:0]          dfs_next, dfs2_reg;
    logic [DEN_W-1:0]        den2_reg;

    always_comb begin
        p_next   = spx_reg * $signed({1'b0, big_reg});
        q_next   = smx_reg * $signed({1'b0, big_reg});
        rd_next  = r1_reg * $signed({1'b0, den1_reg});
        dfs_next = FDW'(den1_reg) * FDW'(FS_C);
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            p_reg    <= p_next;
            q_reg    <= q_next;
            rd_reg   <= rd_next;
            dfs2_reg <= dfs_next;
            den2_reg <= den1_reg;
        end
    end

    // stage 3: wheel numerators
    logic signed [NUM_W-1:0] num_reg [LANES];
    logic [FDW-1:0]          dfs3_reg;
    logic [DEN_W-1:0]        den3_reg;

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            num_reg[0] <= p_reg + rd_reg;  // front left
            num_reg[1] <= q_reg + rd_reg;  // back left
            num_reg[2] <= q_reg - rd_reg;  // front right
            num_reg[3] <= p_reg - rd_reg;  // back right
            dfs3_reg   <= dfs2_reg;
            den3_reg   <= den2_reg;
        end
    end

    // stage 4: sign and magnitude
    logic [MAG_W-1:0] mag_reg [LANES];
    logic [LANES-1:0] neg4_reg;
    logic [FDW-1:0]   dfs4_reg;
    logic [DEN_W-1:0] den4_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            for (int i = 0; i < LANES; i++) begin
                mag_reg[i]  <= num_reg[i][NUM_W-1] ? MAG_W'(-num_reg[i])
                                                   : MAG_W'(num_reg[i]);
                neg4_reg[i] <= num_reg[i][NUM_W-1];
            end
            dfs4_reg <= dfs3_reg;
            den4_reg <= den3_reg;
        end
    end

    // stage 5: peak, limit check, divider operands
    logic [MAG_W-1:0]       pk01, pk23, peak;
    logic                   scale;
    logic [MAG_W+FSW-1:0]   mfs [LANES];
    logic [DW-1:0]          dvd_next [LANES];
    logic [DW-1:0]          dvd_reg  [LANES];
    logic [MAG_W-1:0]       dvs_next, dvs_reg;
    logic [LANES-1:0]       neg5_reg;

    always_comb begin
        pk01     = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        pk23     = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
        peak     = (pk01 > pk23) ? pk01 : pk23;
        scale    = peak > MAG_W'(dfs4_reg);
        dvs_next = scale ? peak : MAG_W'(den4_reg);
        for (int i = 0; i < LANES; i++) begin
            mfs[i]      = (MAG_W + FSW)'(mag_reg[i]) * (MAG_W + FSW)'(FS_C);
            dvd_next[i] = scale ? {mfs[i], {FRAC_W{1'b0}}}
                                : DW'({mag_reg[i], {FRAC_W{1'b0}}});
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            for (int i = 0; i < LANES; i++) begin
                dvd_reg[i] <= dvd_next[i];
            end
            dvs_reg  <= dvs_next;
            neg5_reg <= neg4_reg;
        end
    end

    // divider lanes
    logic [QW-1:0]    quo [LANES];
    logic [LANES-1:0] quo_neg;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        xdjm_div #(
            .DW (DW),
            .VW (MAG_W),
            .QW (QW)
        ) u_div (
            .aclk  (aclk),
            .en    (rdy[PRE +: QW]),
            .dvd_i (dvd_reg[i]),
            .dvs_i (dvs_reg),
            .neg_i (neg5_reg[i]),
            .quo_o (quo[i]),
            .neg_o (quo_neg[i])
        );
    end

    // output stage: restore sign
    logic [OUT_W-1:0] spd_reg [LANES];

    always_ff @(posedge aclk) begin
        if (rdy[OST]) begin
            for (int i = 0; i < LANES; i++) begin
                spd_reg[i] <= quo_neg[i] ? (~OUT_W'(quo[i]) + 1'b1) : OUT_W'(quo[i]);
            end
        end
    end

    assign m_tdata = {spd_reg[3], spd_reg[2], spd_reg[1], spd_reg[0]};

endmodule

// ----- rtl/core/xdjm_checker.sv -----
// port-level checks for the x-drive joystick mixer, bound to the top level
module xdjm_checker import xdjm_pkg::*; #(
    parameter int FULL_SCALE = DEF_FULL_SCALE
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    localparam logic signed [OUT_W-1:0] LIM = OUT_W'(FULL_SCALE * 256);

    logic in_range;

    always_comb begin
        in_range = 1'b1;
        for (int i = 0; i < LANES; i++) begin
            if ($signed(m_tdata[i*OUT_W +: OUT_W]) > LIM ||
                $signed(m_tdata[i*OUT_W +: OUT_W]) < -LIM) begin
                in_range = 1'b0;
            end
        end
    end

    // a held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // wheel speeds never exceed full scale
    a_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> in_range)
        else $error("wheel speed beyond full scale");

    // empty output register means the pipeline can take an item
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind x_drive_joystick_mixer_core xdjm_checker #(
    .FULL_SCALE (FULL_SCALE)
) u_xdjm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/tb_top.sv -----
// self-checking stream testbench for the x-drive joystick mixer core
module tb_top;
    import xdjm_pkg::*;

    localparam int WHEEL_LIMIT = DEF_FULL_SCALE;
    localparam int NUM_RANDOM  = 1080;
    localparam int DRAIN_WAIT  = 40;
    localparam int LONG_STALL  = 400;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [OUT_W-1:0]  speed_t;

    // fl_spd in the lowest bits, as on m_tdata
    typedef struct packed {
        speed_t br_spd;
        speed_t fr_spd;
        speed_t bl_spd;
        speed_t fl_spd;
    } wheels_t;

    typedef struct packed {
        axis_t  fwd;
        axis_t  str;
        axis_t  trn;
        bit     typed;
        speed_t fl;
        speed_t bl;
        speed_t fr;
        speed_t br;
    } stim_row_t;

    localparam int NUM_ROWS = 23;
    localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
        '{   0,    0,    0, 1,      0,      0,      0,      0},
        '{ 100,    0,    0, 1,  25600,  25600,  25600,  25600},
        '{-100,    0,    0, 1, -25600, -25600, -25600, -25600},
        '{   0,  100,    0, 1,  25600, -25600, -25600,  25600},
        '{   0, -100,    0, 1, -25600,  25600,  25600, -25600},
        '{   0,    0,  100, 1,  25600,  25600, -25600, -25600},
        '{   0,    0, -100, 1, -25600, -25600,  25600,  25600},
        '{   0,    0, -128, 1, -25600, -25600,  25600,  25600},
        '{   0,    0,  127, 1,  25600,  25600, -25600, -25600},
        '{   0,    0,    1, 1,    256,    256,   -256,   -256},
        '{   0,    0,   -1, 1,   -256,   -256,    256,    256},
        '{-128, -128, -128, 1, -25600, -12800,  12800,      0},
        '{ 127,  127,  127, 0,      0,      0,      0,      0},
        '{ 127, -128,    0, 0,      0,      0,      0,      0},
        '{-128,  127, -128, 0,      0,      0,      0,      0},
        '{  50,   50,    0, 0,      0,      0,      0,      0},
        '{   1,   -1,    1, 0,      0,      0,      0,      0},
        '{  30,   40,   50, 0,      0,      0,      0,      0},
        '{ -70,   20,  -90, 0,      0,      0,      0,      0},
        '{ 100,  100,  100, 0,      0,      0,      0,      0},
        '{   3,    7,    0, 0,      0,      0,      0,      0},
        '{  -3,    7,    0, 0,      0,      0,      0,      0},
        '{ 100, -100, -100, 0,      0,      0,      0,      0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // forward_axis, strafe_axis, turn_axis
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // fl, bl, fr, br wheel speed

    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    int      phase       = 0;
    int      stall_left  = 0;
    bit      stall_done  = 1'b0;
    int      errors      = 0;
    wheels_t wheel_queue [$];

    x_drive_joystick_mixer_core #(.FULL_SCALE(WHEEL_LIMIT)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // exact rational mix, truncated toward zero in percent times 256
    function automatic wheels_t mix_wheels(axis_t fwd, axis_t str, axis_t trn);
        longint  y = fwd;
        longint  x = str;
        longint  r = trn;
        longint  ax, ay, den, big, peak;
        longint  mix [4];
        speed_t  lane [4];
        wheels_t res;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        big = (ax > ay) ? ax : ay;
        if (ax + ay != 0) begin
            den = ax + ay;
            mix[0] = (y + x) * big + r * den;
            mix[1] = (y - x) * big + r * den;
            mix[2] = (y - x) * big - r * den;
            mix[3] = (y + x) * big - r * den;
        end else begin
            den = 1;
            mix[0] = r;
            mix[1] = r;
            mix[2] = -r;
            mix[3] = -r;
        end
        peak = 0;
        for (int i = 0; i < 4; i++) begin
            if ((mix[i] < 0 ? -mix[i] : mix[i]) > peak)
                peak = (mix[i] < 0) ? -mix[i] : mix[i];
        end
        for (int i = 0; i < 4; i++) begin
            if (peak > WHEEL_LIMIT * den)
                lane[i] = speed_t'((mix[i] * 256 * WHEEL_LIMIT) / peak);
            else
                lane[i] = speed_t'((mix[i] * 256) / den);
        end
        res.fl_spd = lane[0];
        res.bl_spd = lane[1];
        res.fr_spd = lane[2];
        res.br_spd = lane[3];
        return res;
    endfunction

    // mostly nominal stick range, with zeros, extremes and raw bytes mixed in
    function automatic axis_t pick_axis();
        int    pick;
        axis_t v;
        pick = $urandom_range(9);
        case (pick)
            0: begin
                v = '0;
            end
            1: begin
                case ($urandom_range(3))
                    0: v = -128;
                    1: v = -100;
                    2: v = 100;
                    default: v = 127;
                endcase
            end
            2: begin
                v = axis_t'($urandom);
            end
            default: begin
                v = axis_t'(int'($urandom_range(200)) - 100);
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input axis_t fwd, input axis_t str, input axis_t trn,
                             input bit typed, input wheels_t typed_speeds);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {trn, str, fwd};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        wheel_queue.push_back(typed ? typed_speeds : mix_wheels(fwd, str, trn));
    endtask

    task automatic compare_speed(input string name, input speed_t want, input speed_t got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // long receiver hold-off at the start of the no-idle phase, so the pipe fills
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end else if (!stall_done && phase == 2) begin
            stall_left <= LONG_STALL;
            stall_done <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= (stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        wheels_t got;
        wheels_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (wheel_queue.size() == 0) begin
                $error("result with no item outstanding: %h", m_tdata);
                errors++;
            end else begin
                want = wheel_queue.pop_front();
                compare_speed("fl_speed", want.fl_spd, got.fl_spd);
                compare_speed("bl_speed", want.bl_spd, got.bl_spd);
                compare_speed("fr_speed", want.fr_spd, got.fr_spd);
                compare_speed("br_speed", want.br_spd, got.br_spd);
            end
        end
    end

    initial begin
        axis_t   fwd, str, trn;
        wheels_t typed_speeds;
        int      guard;
        tx_idle_pct <= 18;
        rx_idle_pct <= 73;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            typed_speeds.fl_spd = STIM_ROWS[i].fl;
            typed_speeds.bl_spd = STIM_ROWS[i].bl;
            typed_speeds.fr_spd = STIM_ROWS[i].fr;
            typed_speeds.br_spd = STIM_ROWS[i].br;
            send_item(STIM_ROWS[i].fwd, STIM_ROWS[i].str, STIM_ROWS[i].trn,
                      STIM_ROWS[i].typed, typed_speeds);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 3) begin
                tx_idle_pct <= 73;
                rx_idle_pct <= 18;
            end else if (n == 2 * NUM_RANDOM / 3) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
                phase       <= 2;
            end
            fwd = pick_axis();
            str = pick_axis();
            trn = pick_axis();
            // centered translation stick now and then
            if ($urandom_range(19) == 0) begin
                fwd = '0;
                str = '0;
            end
            send_item(fwd, str, trn, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        for (guard = 0; wheel_queue.size() != 0 && guard < 20000; guard++)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (wheel_queue.size() != 0) begin
            $error("%0d results never arrived", wheel_queue.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
